### src/fbenc_pkg.sv
// Package for the five-byte to eight-symbol encoder: sizes, types and the code-to-ASCII map.
// Has no dependencies. The interfaces and all encoder modules import it.
`timescale 1ns / 1ps
`default_nettype none

package fbenc_pkg;

    localparam int GROUP_BYTES   = 5;
    localparam int STORE_DEPTH   = GROUP_BYTES - 1;
    localparam int BLOCK_SYMBOLS = 8;
    localparam int CODE_W        = 5;
    localparam int SYMBOL_W      = 7;
    localparam int GROUP_W       = 8 * GROUP_BYTES;
    localparam int FILL_W        = 3;
    localparam int STORE_IDX_W   = 2;

    // Input kinds.
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [CODE_W-1:0]   LETTER_COUNT = 5'd26;
    localparam logic [SYMBOL_W-1:0] CHAR_A       = 7'h61;
    // Code 26 maps to '0' (0x30), so digits are the code plus 22.
    localparam logic [SYMBOL_W-1:0] DIGIT_OFFSET = 7'd22;

    typedef logic [7:0]          byte_t;
    typedef logic [GROUP_W-1:0]  group_t;
    typedef logic [CODE_W-1:0]   code_t;
    typedef logic [SYMBOL_W-1:0] symbol_t;
    typedef logic [FILL_W-1:0]   fill_t;
    typedef symbol_t [BLOCK_SYMBOLS-1:0] block_t;

    function automatic symbol_t code_to_symbol(input code_t code);
        symbol_t wide_code;
        wide_code = {{(SYMBOL_W-CODE_W){1'b0}}, code};
        if (code < LETTER_COUNT)
        begin
            return CHAR_A + wide_code;
        end
        return wide_code + DIGIT_OFFSET;
    endfunction

endpackage

`default_nettype wire

### src/fbenc_if.sv
// Stream interfaces of the encoder: the byte channel and the symbol block channel.
// Each carries valid, ready and its payload. Depends on fbenc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface fbenc_byte_if;
    import fbenc_pkg::*;

    logic  valid;
    logic  ready;
    logic  kind;
    byte_t data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface fbenc_block_if;
    import fbenc_pkg::*;

    logic    valid;
    logic    ready;
    symbol_t symbol_0;
    symbol_t symbol_1;
    symbol_t symbol_2;
    symbol_t symbol_3;
    symbol_t symbol_4;
    symbol_t symbol_5;
    symbol_t symbol_6;
    symbol_t symbol_7;
    logic    final_block;

    modport source (output valid, output symbol_0, output symbol_1, output symbol_2,
                    output symbol_3, output symbol_4, output symbol_5, output symbol_6,
                    output symbol_7, output final_block, input ready);
    modport sink   (input valid, input symbol_0, input symbol_1, input symbol_2,
                    input symbol_3, input symbol_4, input symbol_5, input symbol_6,
                    input symbol_7, input final_block, output ready);
endinterface

`default_nettype wire

### src/five_byte_to_eight_char_encoder.sv
// Top level of the five-byte to eight-symbol encoder: byte collection, padding and output.
// Depends on fbenc_pkg, fbenc_if and fbenc_symbol_map.
`timescale 1ns / 1ps
`default_nettype none

// The encoder takes one request per clock on byte_ch while byte_ch is ready, either a data
// byte or an end-of-stream mark, and sends one block of eight ASCII symbols on block_ch for
// every fifth data byte and for every end-of-stream mark. Throughput is one request per cycle
// with no gaps while block_ch takes blocks, also while blocks are being produced. A closed
// group goes into the group register (the assembled 40-bit group) and from there into the
// output register (the mapped symbols). When block_ch stalls, these two registers absorb it,
// and byte_ch stops accepting only when both are full. An end-of-stream mark pads the open
// group with 0x80 in its first empty byte and zeros after it, and the block is flagged with
// final_block; an empty group therefore gives "qaaaaaaa". Each mark starts a new stream.
module five_byte_to_eight_char_encoder (
    input  wire logic     clk,
    input  wire logic     rst_n,
    fbenc_byte_if.sink    byte_ch,
    fbenc_block_if.source block_ch
);
    import fbenc_pkg::*;

    // Open group: first four bytes and how many of them are held.
    byte_t  store_reg [STORE_DEPTH];
    fill_t  fill_count_reg;
    fill_t  fill_count_next;

    // Group stage.
    logic   grp_valid_reg;
    logic   grp_valid_next;
    group_t grp_data_reg;
    logic   grp_final_reg;

    // Output stage.
    logic   out_valid_reg;
    logic   out_valid_next;
    block_t out_symbols_reg;
    logic   out_final_reg;

    logic   byte_fire;
    logic   group_full;
    logic   emit;
    logic   out_load_ok;
    logic   grp_advance;
    group_t group_next;
    block_t symbols;

    assign byte_fire   = byte_ch.valid && byte_ch.ready;
    assign group_full  = (fill_count_reg == fill_t'(STORE_DEPTH));
    // A block goes out for an end-of-stream mark or for the byte that completes a group.
    assign emit        = (byte_ch.kind == KIND_END) || group_full;
    assign out_load_ok = !out_valid_reg || block_ch.ready;
    assign grp_advance = grp_valid_reg && out_load_ok;

    assign byte_ch.ready = !grp_valid_reg || out_load_ok;

    // Assemble the group. Bytes below the fill count come from the store, a data byte fills the
    // last byte, the first empty byte takes the pad mark at end of stream, and the rest are zero
    // so that stale entries never reach the output.
    always_comb
    begin
        group_next = '0;
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            if (fill_t'(i) < fill_count_reg)
            begin
                group_next[GROUP_W-1-8*i -: 8] = store_reg[i];
            end
            else if ((fill_t'(i) == fill_count_reg) && (byte_ch.kind == KIND_END))
            begin
                group_next[GROUP_W-1-8*i -: 8] = PAD_MARK;
            end
        end
        if (byte_ch.kind == KIND_DATA)
        begin
            group_next[7:0] = byte_ch.data_byte;
        end
        else if (group_full)
        begin
            group_next[7:0] = PAD_MARK;
        end
    end

    always_comb
    begin
        fill_count_next = fill_count_reg;
        if (byte_fire)
        begin
            fill_count_next = emit ? '0 : fill_count_reg + fill_t'(1);
        end
    end

    always_comb
    begin
        grp_valid_next = grp_valid_reg;
        if (byte_fire && emit)
        begin
            grp_valid_next = 1'b1;
        end
        else if (grp_advance)
        begin
            grp_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (grp_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (block_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            grp_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            fill_count_reg <= fill_count_next;
            grp_valid_reg  <= grp_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Byte store and payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (byte_fire && !emit)
        begin
            store_reg[fill_count_reg[STORE_IDX_W-1:0]] <= byte_ch.data_byte;
        end
        if (byte_fire && emit)
        begin
            grp_data_reg  <= group_next;
            grp_final_reg <= (byte_ch.kind == KIND_END);
        end
        if (grp_advance)
        begin
            out_symbols_reg <= symbols;
            out_final_reg   <= grp_final_reg;
        end
    end

    fbenc_symbol_map u_symbol_map (
        .group   (grp_data_reg),
        .symbols (symbols)
    );

    assign block_ch.valid       = out_valid_reg;
    assign block_ch.symbol_0    = out_symbols_reg[0];
    assign block_ch.symbol_1    = out_symbols_reg[1];
    assign block_ch.symbol_2    = out_symbols_reg[2];
    assign block_ch.symbol_3    = out_symbols_reg[3];
    assign block_ch.symbol_4    = out_symbols_reg[4];
    assign block_ch.symbol_5    = out_symbols_reg[5];
    assign block_ch.symbol_6    = out_symbols_reg[6];
    assign block_ch.symbol_7    = out_symbols_reg[7];
    assign block_ch.final_block = out_final_reg;

`ifndef SYNTHESIS
    // The open group never holds more than four bytes.
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= fill_t'(STORE_DEPTH))
        else $error("fill count beyond the store depth");

    // Any end-of-stream mark closes the group.
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        byte_fire && (byte_ch.kind == KIND_END) |=> fill_count_reg == '0 && grp_valid_reg
        && grp_final_reg)
        else $error("end of stream did not close the group");

    // The fifth data byte produces a non-final block.
    a_full_emits: assert property (@(posedge clk) disable iff (!rst_n)
        byte_fire && (byte_ch.kind == KIND_DATA) && group_full |=> grp_valid_reg
        && !grp_final_reg && fill_count_reg == '0)
        else $error("completed group was not passed on");

    // A group held back by a stalled output stays intact.
    a_grp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        grp_valid_reg && !out_load_ok |=> grp_valid_reg && $stable(grp_data_reg)
        && $stable(grp_final_reg))
        else $error("stalled group was lost or changed");

    // A moving group always lands in the output register.
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        grp_advance |=> out_valid_reg && out_final_reg == $past(grp_final_reg))
        else $error("group did not reach the output register");
`endif

endmodule

`default_nettype wire

### src/fbenc_symbol_map.sv
// Combinational map of one 40-bit group to eight ASCII symbols (interleaved bit codes).
// Depends on fbenc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbenc_symbol_map (
    input  fbenc_pkg::group_t group,
    output fbenc_pkg::block_t symbols
);
    import fbenc_pkg::*;

    localparam int PAIRS = BLOCK_SYMBOLS / 2;

    code_t code_odd  [PAIRS];
    code_t code_even [PAIRS];

    // Odd bits of the group, MSB first, feed the even-numbered symbols; even bits the others.
    for (genvar k = 0; k < PAIRS; k++)
    begin : g_pair
        for (genvar j = 0; j < CODE_W; j++)
        begin : g_bit
            assign code_odd[k][CODE_W-1-j]  = group[GROUP_W-1-2*(CODE_W*k+j)];
            assign code_even[k][CODE_W-1-j] = group[GROUP_W-2-2*(CODE_W*k+j)];
        end
        assign symbols[2*k]   = code_to_symbol(code_odd[k]);
        assign symbols[2*k+1] = code_to_symbol(code_even[k]);
    end

endmodule

`default_nettype wire
